// ===== rtl/dcf_pkg.sv =====
// ---------------------------------------------------------------------------
// dcf_pkg: shared types and constants of the decimating complex FIR
// Field widths, the cell control bundle, the sequencer states and the
// action codes used by the cells, the MAC and the top level.
// ---------------------------------------------------------------------------
package dcf_pkg;

    // Field widths fixed by the item format.
    localparam int SAMPLE_W    = 16;
    localparam int TAP_W       = 18;
    localparam int TAP_INDEX_W = 7;
    localparam int DECIM_W     = 7;
    localparam int DECIM_CNT_W = 6;
    localparam int OUT_W       = 42;

    // Product of one sample part and one tap part, and the sum of two.
    localparam int PROD_W      = SAMPLE_W + TAP_W;
    localparam int PAIR_W      = PROD_W + 1;

    // Largest decimation factor; larger settings saturate to it.
    localparam int DECIM_MAX   = 64;

    // Default filter length.
    localparam int DEF_NUM_TAPS = 128;

    // Action codes of an input item.
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_TAP  = 1'b1;

    // One complex sample, Q1.15.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
    } sample_t;

    // One complex coefficient, Q1.17.
    typedef struct packed {
        logic signed [TAP_W-1:0] re;
        logic signed [TAP_W-1:0] im;
    } tap_t;

    // Control shared by every cell of the row.
    typedef struct packed {
        logic push;     // shift a new sample in at cell 0
        logic rotate;   // rotate history and taps one place toward cell 0
        logic tap_we;   // write the coefficient to the addressed cell
    } cell_ctrl_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/dcf_in_if.sv =====
// ---------------------------------------------------------------------------
// dcf_in_if: input item channel
// Valid/ready channel that carries one sample push or one tap write.
// ---------------------------------------------------------------------------
interface dcf_in_if;
    import dcf_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          action;
    logic signed [SAMPLE_W-1:0]    sample_re;
    logic signed [SAMPLE_W-1:0]    sample_im;
    logic        [TAP_INDEX_W-1:0] tap_index;
    logic signed [TAP_W-1:0]       tap_re;
    logic signed [TAP_W-1:0]       tap_im;

    modport source (
        output valid, action, sample_re, sample_im, tap_index, tap_re, tap_im,
        input  ready
    );

    modport sink (
        input  valid, action, sample_re, sample_im, tap_index, tap_re, tap_im,
        output ready
    );

endinterface

// ===== rtl/dcf_out_if.sv =====
// ---------------------------------------------------------------------------
// dcf_out_if: result channel
// Valid/ready channel that carries one complex filter output.
// ---------------------------------------------------------------------------
interface dcf_out_if;
    import dcf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] out_re;
    logic signed [OUT_W-1:0] out_im;

    modport source (
        output valid, out_re, out_im,
        input  ready
    );

    modport sink (
        input  valid, out_re, out_im,
        output ready
    );

endinterface

// ===== rtl/dcf_cell.sv =====
// ---------------------------------------------------------------------------
// dcf_cell: one position of the filter row
// Holds one history sample and one coefficient. A push shifts samples one
// place away from cell 0; a rotate moves both one place toward cell 0.
// ---------------------------------------------------------------------------
module dcf_cell
    import dcf_pkg::*;
#(
    parameter int CELL_INDEX = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cell_ctrl_t             ctrl,
    input  sample_t                prev_sample,
    input  sample_t                next_sample,
    input  tap_t                   next_tap,
    input  logic [TAP_INDEX_W-1:0] tap_index,
    input  tap_t                   tap_wr,
    output sample_t                sample_q,
    output tap_t                   tap_q
);

    sample_t sample_reg;
    sample_t sample_next;
    tap_t    tap_reg;
    tap_t    tap_next;
    logic    tap_hit;

    // A tap write lands only in the cell whose position matches the index.
    assign tap_hit = (int'(tap_index) == CELL_INDEX);

    // Next sample: shift in on a push, move toward cell 0 on a rotate.
    always_comb
    begin
        sample_next = sample_reg;
        if (ctrl.push)
        begin
            sample_next = prev_sample;
        end
        else if (ctrl.rotate)
        begin
            sample_next = next_sample;
        end
    end

    // Next coefficient: written by a tap transfer, rotated during a sum.
    always_comb
    begin
        tap_next = tap_reg;
        if (ctrl.tap_we && tap_hit)
        begin
            tap_next = tap_wr;
        end
        else if (ctrl.rotate)
        begin
            tap_next = next_tap;
        end
    end

    // History clears at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
        end
    end

    // Coefficients hold whatever is written; they have no reset value.
    always_ff @(posedge clk)
    begin
        tap_reg <= tap_next;
    end

    assign sample_q = sample_reg;
    assign tap_q    = tap_reg;

endmodule

// ===== rtl/dcf_mac.sv =====
// ---------------------------------------------------------------------------
// dcf_mac: complex multiply-accumulate
// Registers the four partial products of one sample and one tap, then adds
// the real and imaginary pairs into 42-bit wrapping accumulators.
// ---------------------------------------------------------------------------
module dcf_mac
    import dcf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    clear,
    input  logic                    load,
    input  sample_t                 sample,
    input  tap_t                    tap,
    output logic signed [OUT_W-1:0] acc_re,
    output logic signed [OUT_W-1:0] acc_im
);

    logic signed [PROD_W-1:0] rr_reg;
    logic signed [PROD_W-1:0] ii_reg;
    logic signed [PROD_W-1:0] ri_reg;
    logic signed [PROD_W-1:0] ir_reg;
    logic                     prod_valid_reg;
    logic signed [PAIR_W-1:0] pair_re;
    logic signed [PAIR_W-1:0] pair_im;
    logic signed [OUT_W-1:0]  acc_re_reg;
    logic signed [OUT_W-1:0]  acc_im_reg;
    logic signed [OUT_W-1:0]  acc_re_next;
    logic signed [OUT_W-1:0]  acc_im_next;

    // Product stage: four exact 16 x 18 products.
    always_ff @(posedge clk)
    begin
        rr_reg <= sample.re * tap.re;
        ii_reg <= sample.im * tap.im;
        ri_reg <= sample.re * tap.im;
        ir_reg <= sample.im * tap.re;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= load && !clear;
        end
    end

    // Combine the products into one complex term.
    assign pair_re = PAIR_W'(rr_reg) - PAIR_W'(ii_reg);
    assign pair_im = PAIR_W'(ri_reg) + PAIR_W'(ir_reg);

    // Accumulate stage; the sum wraps in two's complement at 42 bits.
    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        if (clear)
        begin
            acc_re_next = '0;
            acc_im_next = '0;
        end
        else if (prod_valid_reg)
        begin
            acc_re_next = acc_re_reg + OUT_W'(pair_re);
            acc_im_next = acc_im_reg + OUT_W'(pair_im);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_re_reg <= acc_re_next;
        acc_im_reg <= acc_im_next;
    end

    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;

endmodule

// ===== rtl/decimating_complex_fir.sv =====
// A sample transfer that completes a decimation period starts a sum; tap
// writes and other samples are taken without one. Items are held off until
// the sum's result is loaded. The single complex MAC sees one tap per cycle
// as the cell row rotates.
// Reset (rst_n, asynchronous, active low) clears history, sequencer state, tap
// counter, decimation counter and result valid flag; the factor resets to 1.
// ---------------------------------------------------------------------------
// decimating_complex_fir: decimating complex FIR filter
// A row of cells holds the history (newest in cell 0) and the coefficients.
// On each output the row rotates once around while cell 0 feeds the MAC.
// ---------------------------------------------------------------------------
module decimating_complex_fir
    import dcf_pkg::*;
#(
    parameter int NUM_TAPS = DEF_NUM_TAPS
) (
    input  logic               clk,
    input  logic               rst_n,
    dcf_in_if.sink             items,
    dcf_out_if.source          results,
    input  logic               cfg_we,
    input  logic [DECIM_W-1:0] cfg_data
);

    localparam int CNT_W = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;

    state_t                  state_reg;
    state_t                  state_next;
    logic [CNT_W-1:0]        tap_cnt_reg;
    logic [CNT_W-1:0]        tap_cnt_next;
    logic [DECIM_W-1:0]      decim_factor_reg;
    logic [DECIM_CNT_W-1:0]  decim_cnt_reg;
    logic [DECIM_CNT_W-1:0]  decim_cnt_next;
    logic [DECIM_W-1:0]      decim_eff;
    logic [DECIM_W-1:0]      decim_cnt_plus;
    logic                    accept;
    logic                    push;
    logic                    emit;
    logic                    last_tap;
    logic                    out_free;
    logic                    out_load;
    logic                    mac_load;
    logic                    rotate_en;
    cell_ctrl_t              cell_ctrl;
    sample_t                 new_sample;
    tap_t                    new_tap;
    sample_t                 sample_q [NUM_TAPS];
    tap_t                    tap_q    [NUM_TAPS];
    logic signed [OUT_W-1:0] acc_re;
    logic signed [OUT_W-1:0] acc_im;
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] out_re_reg;
    logic signed [OUT_W-1:0] out_im_reg;

    // Input transfer decode.
    assign accept = items.valid && items.ready;
    assign push   = accept && (items.action == ACT_PUSH);

    // Effective factor: zero acts as 1, anything above the maximum saturates.
    always_comb
    begin
        decim_eff = decim_factor_reg;
        if (decim_factor_reg == '0)
        begin
            decim_eff = DECIM_W'(1);
        end
        else if (decim_factor_reg > DECIM_W'(DECIM_MAX))
        begin
            decim_eff = DECIM_W'(DECIM_MAX);
        end
    end

    assign decim_cnt_plus = DECIM_W'(decim_cnt_reg) + DECIM_W'(1);
    assign emit           = push && (decim_cnt_plus >= decim_eff);

    // Decimation counter advances on every sample and clears on an output.
    always_comb
    begin
        decim_cnt_next = decim_cnt_reg;
        if (emit)
        begin
            decim_cnt_next = '0;
        end
        else if (push)
        begin
            decim_cnt_next = decim_cnt_plus[DECIM_CNT_W-1:0];
        end
    end

    assign last_tap = (tap_cnt_reg == CNT_W'(NUM_TAPS - 1));
    assign out_free = !out_valid_reg || results.ready;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (emit)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (last_tap)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic of the sequencer.
    always_comb
    begin
        items.ready  = 1'b0;
        mac_load     = 1'b0;
        out_load     = 1'b0;
        rotate_en    = 1'b0;
        tap_cnt_next = '0;
        case (state_reg)
            ST_IDLE:
            begin
                items.ready = 1'b1;
            end
            ST_SUM:
            begin
                mac_load     = 1'b1;
                rotate_en    = 1'b1;
                tap_cnt_next = tap_cnt_reg + CNT_W'(1);
            end
            ST_DRAIN:
            begin
                mac_load = 1'b0;
            end
            ST_FINISH:
            begin
                out_load = out_free;
            end
            default:
            begin
                items.ready = 1'b0;
            end
        endcase
    end

    assign cell_ctrl = '{push:   push,
                         rotate: rotate_en,
                         tap_we: accept && (items.action == ACT_TAP)};

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            tap_cnt_reg      <= '0;
            decim_cnt_reg    <= '0;
            decim_factor_reg <= DECIM_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            tap_cnt_reg   <= tap_cnt_next;
            decim_cnt_reg <= decim_cnt_next;
            if (cfg_we)
            begin
                decim_factor_reg <= cfg_data;
            end
        end
    end

    assign new_sample.re = items.sample_re;
    assign new_sample.im = items.sample_im;
    assign new_tap.re    = items.tap_re;
    assign new_tap.im    = items.tap_im;

    // Row of cells: samples shift away from cell 0, the ring rotates back.
    for (genvar i = 0; i < NUM_TAPS; i++)
    begin : g_cell
        sample_t prev_sample;

        if (i == 0)
        begin : g_head
            assign prev_sample = new_sample;
        end
        else
        begin : g_body
            assign prev_sample = sample_q[i-1];
        end

        dcf_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .prev_sample (prev_sample),
            .next_sample (sample_q[(i + 1) % NUM_TAPS]),
            .next_tap    (tap_q[(i + 1) % NUM_TAPS]),
            .tap_index   (items.tap_index),
            .tap_wr      (new_tap),
            .sample_q    (sample_q[i]),
            .tap_q       (tap_q[i])
        );
    end

    // Cell 0 feeds the MAC; the accumulators clear when a sum starts.
    dcf_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (emit),
        .load   (mac_load),
        .sample (sample_q[0]),
        .tap    (tap_q[0]),
        .acc_re (acc_re),
        .acc_im (acc_im)
    );

    // Result register; the next items are taken while a result waits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_re_reg <= acc_re;
            out_im_reg <= acc_im;
        end
    end

    assign results.valid  = out_valid_reg;
    assign results.out_re = out_re_reg;
    assign results.out_im = out_im_reg;

endmodule

// ===== rtl/dcf_checker.sv =====
// ---------------------------------------------------------------------------
// dcf_checker: port-level checks of the decimating complex FIR
// Watches the channels of the top level and is bound to it below.
// ---------------------------------------------------------------------------
module dcf_checker
    import dcf_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    in_action,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [OUT_W-1:0] out_re,
    input logic signed [OUT_W-1:0] out_im
);

    // A stalled result stays valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_re) && $stable(out_im))
        else $error("result changed while stalled");

    // A new result appears only at the end of a sum, while inputs are held off.
    a_rose_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while the block was idle");

    // A tap write never starts a sum, so the block stays ready.
    a_tap_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_action == ACT_TAP) |=> in_ready)
        else $error("tap write stalled the input");

endmodule

bind decimating_complex_fir dcf_checker u_dcf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .in_action (items.action),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_re    (results.out_re),
    .out_im    (results.out_im)
);
